// ----- rtl/core/chmc_pkg.sv -----
package chmc_pkg;

  localparam int unsigned COORD_W = 20;

  typedef struct packed {
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] x;
  } point_t;

  typedef enum logic [1:0] {
    PUSH_P     = 2'd0,
    PUSH_CELL0 = 2'd1,
    PUSH_CELL1 = 2'd2,
    PUSH_NM2   = 2'd3
  } push_src_t;

  typedef struct packed {
    logic      load;
    logic      sort_init;
    logic      sort_step;
    logic      push;
    push_src_t push_src;
    logic      seed_clr;
    logic      seed_done;
    logic      fetch;
    logic      mul;
    logic      pop;
    logic      advance;
    logic      mid;
    logic      pass_thru;
    logic      emit_adv;
    logic      finish;
  } cmd_t;

  typedef struct packed {
    logic small_set;
    logic sort_done;
    logic chain_end;
    logic right_phase;
    logic can_pop;
    logic turn_le0;
    logic emit_last;
  } sts_t;

endpackage

// ----- rtl/core/chmc_if.sv -----
interface chmc_in_if;
  import chmc_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] point_x;
  logic signed [COORD_W-1:0] point_y;
  logic                      last_point;
  modport source (output valid, output point_x, output point_y, output last_point,
                  input ready);
  modport sink (input valid, input point_x, input point_y, input last_point,
                output ready);
endinterface

interface chmc_out_if;
  import chmc_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] hull_x;
  logic signed [COORD_W-1:0] hull_y;
  logic                      last_vertex;
  logic                      overflowed;
  modport source (output valid, output hull_x, output hull_y, output last_vertex,
                  output overflowed, input ready);
  modport sink (input valid, input hull_x, input hull_y, input last_vertex,
                input overflowed, output ready);
endinterface

// ----- rtl/core/chmc_datapath.sv -----
module chmc_datapath
  import chmc_pkg::*;
#(
  parameter int unsigned MAX_POINTS = 32
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  cmd_t                      cmd,
  output sts_t                      sts,
  input  logic signed [COORD_W-1:0] in_x,
  input  logic signed [COORD_W-1:0] in_y,
  output point_t                    out_pt,
  output logic                      out_ovf
);

  localparam int unsigned SD = MAX_POINTS + 1;
  localparam int unsigned CW = $clog2(MAX_POINTS + 1);
  localparam int unsigned IW = $clog2(MAX_POINTS);
  localparam int unsigned TW = $clog2(SD + 1);
  localparam int unsigned SW = $clog2(SD);
  localparam int unsigned PW = 2 * (COORD_W + 1);

  point_t                 cells_r [MAX_POINTS];
  point_t                 cells_nxt [MAX_POINTS];
  point_t                 stk_mem [SD];
  point_t                 s0_r, s1_r, rd_r, em_r;
  logic [CW-1:0]          cnt_r, pass_r, idx_r;
  logic                   ovf_r, right_r;
  logic [TW-1:0]          top_r, floor_r, e_r;
  logic [TW-1:0]          e_nxt;
  point_t                 p_r;
  logic signed [PW-1:0]   m1_r, m2_r;
  point_t                 push_val, fetch_val;
  logic [CW-1:0]          cnt_after, fetch_idx, nm2;
  logic signed [COORD_W:0] ux, uy, vx, vy;
  logic                   push_ok;
  logic [SW-1:0]          wr_addr, rd_addr, em_addr;

  assign cnt_after = (cnt_r < CW'(MAX_POINTS)) ? cnt_r + 1'b1 : cnt_r;
  assign nm2       = cnt_r - CW'(2);
  assign fetch_idx = right_r ? idx_r : idx_r - 1'b1;
  assign fetch_val = cells_r[fetch_idx[IW-1:0]];

  always_comb begin
    case (cmd.push_src)
      PUSH_P:     push_val = p_r;
      PUSH_CELL0: push_val = cells_r[0];
      PUSH_CELL1: push_val = cells_r[1];
      PUSH_NM2:   push_val = cells_r[nm2[IW-1:0]];
      default:    push_val = p_r;
    endcase
  end

  // odd-even transposition pass, or a point write while loading
  always_comb begin
    for (int j = 0; j < MAX_POINTS; j++) cells_nxt[j] = cells_r[j];
    if (cmd.load && cnt_r < CW'(MAX_POINTS)) begin
      cells_nxt[cnt_r[IW-1:0]] = '{y: in_y, x: in_x};
    end
    if (cmd.sort_step) begin
      for (int j = 0; j + 1 < MAX_POINTS; j++) begin
        if ((j % 2) == int'(pass_r[0]) && (j + 1) < int'(cnt_r) &&
            ((cells_r[j+1].y < cells_r[j].y) ||
             (cells_r[j+1].y == cells_r[j].y && cells_r[j+1].x < cells_r[j].x))) begin
          cells_nxt[j]   = cells_r[j+1];
          cells_nxt[j+1] = cells_r[j];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < MAX_POINTS; j++) cells_r[j] <= cells_nxt[j];
  end

  // hull stack: memory written at the top, two registered read ports
  // rd_r follows the entry under the top two, em_r the next word out
  assign push_ok = cmd.push && (cmd.seed_clr || top_r < TW'(SD));
  assign wr_addr = cmd.seed_clr ? '0 : SW'(top_r);
  assign rd_addr = (top_r >= TW'(3)) ? SW'(top_r - TW'(3)) : '0;
  assign e_nxt   = cmd.finish ? '0 : (cmd.emit_adv ? e_r + 1'b1 : e_r);
  assign em_addr = SW'(e_nxt);

  always_ff @(posedge clk) begin
    if (push_ok) stk_mem[wr_addr] <= push_val;
    rd_r <= stk_mem[rd_addr];
    em_r <= stk_mem[em_addr];
  end

  // top two entries kept in registers for the turn test
  always_ff @(posedge clk) begin
    if (push_ok) begin
      s0_r <= push_val;
      s1_r <= s0_r;
    end else if (cmd.pop) begin
      s0_r <= s1_r;
      s1_r <= rd_r;
    end
  end

  assign ux = (COORD_W+1)'(s0_r.x) - (COORD_W+1)'(s1_r.x);
  assign uy = (COORD_W+1)'(s0_r.y) - (COORD_W+1)'(s1_r.y);
  assign vx = (COORD_W+1)'(p_r.x) - (COORD_W+1)'(s1_r.x);
  assign vy = (COORD_W+1)'(p_r.y) - (COORD_W+1)'(s1_r.y);

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      m1_r <= ux * vy;
      m2_r <= uy * vx;
    end
    if (cmd.fetch) p_r <= fetch_val;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      ovf_r   <= 1'b0;
      pass_r  <= '0;
      idx_r   <= '0;
      right_r <= 1'b1;
      top_r   <= '0;
      floor_r <= '0;
      e_r     <= '0;
    end else begin
      if (cmd.load) begin
        cnt_r <= cnt_after;
        if (cnt_r >= CW'(MAX_POINTS)) ovf_r <= 1'b1;
      end
      if (cmd.sort_init) pass_r <= '0;
      if (cmd.sort_step) pass_r <= pass_r + 1'b1;
      if (cmd.push) begin
        if (cmd.seed_clr) top_r <= TW'(1);
        else if (top_r < TW'(SD)) top_r <= top_r + 1'b1;
      end else if (cmd.pop) begin
        top_r <= top_r - 1'b1;
      end
      if (cmd.seed_done) begin
        idx_r   <= CW'(2);
        right_r <= 1'b1;
        floor_r <= TW'(1);
      end
      if (cmd.advance) idx_r <= right_r ? idx_r + 1'b1 : idx_r - 1'b1;
      if (cmd.mid) begin
        floor_r <= top_r;
        idx_r   <= nm2;
        right_r <= 1'b0;
      end
      if (cmd.emit_adv) e_r <= e_r + 1'b1;
      if (cmd.finish) begin
        e_r   <= '0;
        cnt_r <= '0;
        ovf_r <= 1'b0;
      end
    end
  end

  always_comb begin
    if (cmd.pass_thru) out_pt = cells_r[e_r[IW-1:0]];
    else               out_pt = em_r;
  end
  assign out_ovf = ovf_r;

  assign sts.small_set   = cnt_after <= CW'(3);
  assign sts.sort_done   = pass_r == cnt_r;
  assign sts.right_phase = right_r;
  assign sts.chain_end   = right_r ? (idx_r == cnt_r) : (idx_r == '0);
  assign sts.can_pop     = (top_r > floor_r) && (top_r >= TW'(2));
  assign sts.turn_le0    = m1_r <= m2_r;
  assign sts.emit_last   = cmd.pass_thru ? (e_r == TW'(cnt_r) - 1'b1)
                                         : (e_r == top_r - 1'b1);

endmodule

// ----- rtl/core/chmc_ctrl.sv -----
module chmc_ctrl
  import chmc_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic in_last,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [10:0] {
    S_LOAD  = 11'b00000000001,
    S_SMALL = 11'b00000000010,
    S_SORT  = 11'b00000000100,
    S_SEED0 = 11'b00000001000,
    S_SEED1 = 11'b00000010000,
    S_FETCH = 11'b00000100000,
    S_CHECK = 11'b00001000000,
    S_TEST  = 11'b00010000000,
    S_PUSH  = 11'b00100000000,
    S_MID   = 11'b01000000000,
    S_EMIT  = 11'b10000000000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_LOAD;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.push_src = PUSH_P;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      S_LOAD: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (in_last) begin
            cmd.sort_init = 1'b1;
            state_nxt = sts.small_set ? S_SMALL : S_SORT;
          end
        end
      end
      S_SMALL: begin
        cmd.pass_thru = 1'b1;
        out_valid = 1'b1;
        if (out_ready) begin
          if (sts.emit_last) begin
            cmd.finish = 1'b1;
            state_nxt  = S_LOAD;
          end else begin
            cmd.emit_adv = 1'b1;
          end
        end
      end
      S_SORT: begin
        if (sts.sort_done) state_nxt = S_SEED0;
        else cmd.sort_step = 1'b1;
      end
      S_SEED0: begin
        cmd.push     = 1'b1;
        cmd.seed_clr = 1'b1;
        cmd.push_src = PUSH_CELL0;
        state_nxt    = S_SEED1;
      end
      S_SEED1: begin
        cmd.push      = 1'b1;
        cmd.push_src  = PUSH_CELL1;
        cmd.seed_done = 1'b1;
        state_nxt     = S_FETCH;
      end
      S_FETCH: begin
        if (sts.chain_end) begin
          state_nxt = sts.right_phase ? S_MID : S_EMIT;
        end else begin
          cmd.fetch = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.can_pop) begin
          cmd.mul   = 1'b1;
          state_nxt = S_TEST;
        end else begin
          state_nxt = S_PUSH;
        end
      end
      S_TEST: begin
        if (sts.turn_le0) begin
          cmd.pop   = 1'b1;
          state_nxt = S_CHECK;
        end else begin
          state_nxt = S_PUSH;
        end
      end
      S_PUSH: begin
        cmd.push    = 1'b1;
        cmd.advance = 1'b1;
        state_nxt   = S_FETCH;
      end
      S_MID: begin
        cmd.push     = 1'b1;
        cmd.push_src = PUSH_NM2;
        cmd.mid      = 1'b1;
        state_nxt    = S_FETCH;
      end
      S_EMIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (sts.emit_last) begin
            cmd.finish = 1'b1;
            state_nxt  = S_LOAD;
          end else begin
            cmd.emit_adv = 1'b1;
          end
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

endmodule

// ----- rtl/core/convex_hull_monotone_chain.sv -----
// channel | dir | payload                                   | handshake
// in_ch   | in  | point_x, point_y, last_point              | valid/ready
// out_ch  | out | hull_x, hull_y, last_vertex, overflowed   | valid/ready
//
// points load at one word per cycle; sets of up to three go straight out
// others are sorted by odd-even transposition, seeded, then each chain point is
// fetched, turn-tested (registered 21x21 products, then a compare) and pushed;
// hull words leave one per cycle from the stack while out_ready is high
// input is held off from the last point until the final vertex is taken
// synchronous active-low reset clears counts, flags and the controller only
module convex_hull_monotone_chain
  import chmc_pkg::*;
#(
  parameter int unsigned MAX_POINTS = 32
) (
  input logic clk,
  input logic rst_n,
  chmc_in_if.sink    in_ch,
  chmc_out_if.source out_ch
);

  cmd_t   cmd;
  sts_t   sts;
  point_t out_pt;

  // sequencer: load, small-set pass-through or sort, right chain, left chain, emit
  chmc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_last   (in_ch.last_point),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // point cells, sorter, hull stack and turn test
  chmc_datapath #(
    .MAX_POINTS (MAX_POINTS)
  ) u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .sts     (sts),
    .in_x    (in_ch.point_x),
    .in_y    (in_ch.point_y),
    .out_pt  (out_pt),
    .out_ovf (out_ch.overflowed)
  );

  assign out_ch.hull_x      = out_pt.x;
  assign out_ch.hull_y      = out_pt.y;
  assign out_ch.last_vertex = sts.emit_last;

endmodule

// ----- verif/chmc_hull_checker.sv -----
module chmc_hull_checker
  import chmc_pkg::*;
#(
  parameter int unsigned MAX_POINTS = 32
) (
  input  logic clk,
  input  logic rst_n,
  chmc_in_if   in_ch,
  chmc_out_if  out_ch,
  output int   err_count,
  output int   vertices_due
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic                      last;
    logic                      ovf;
  } vertex_t;

  vertex_t hull_q[$];

  logic signed [COORD_W-1:0] set_x[MAX_POINTS];
  logic signed [COORD_W-1:0] set_y[MAX_POINTS];
  int unsigned set_count;
  logic        set_ovf;

  assign vertices_due = hull_q.size();

  function automatic bit ranks_lower(int a, int b);
    if (set_y[a] != set_y[b]) return set_y[a] < set_y[b];
    return set_x[a] < set_x[b];
  endfunction

  // cross product of (b - a) and (p - a)
  function automatic longint turn_val(int a, int b, int p);
    longint ux, uy, vx, vy;
    ux = longint'(set_x[b]) - longint'(set_x[a]);
    uy = longint'(set_y[b]) - longint'(set_y[a]);
    vx = longint'(set_x[p]) - longint'(set_x[a]);
    vy = longint'(set_y[p]) - longint'(set_y[a]);
    return ux * vy - uy * vx;
  endfunction

  function automatic void add_vertex(int idx, bit last);
    vertex_t v;
    v.x = set_x[idx];
    v.y = set_y[idx];
    v.last = last;
    v.ovf = set_ovf;
    hull_q.push_back(v);
  endfunction

  function automatic void predict_hull();
    int ord[MAX_POINTS];
    int stk[MAX_POINTS+1];
    int n, top, mid, v, j, p;
    n = set_count;
    if (n <= 3) begin
      for (int i = 0; i < n; i++) add_vertex(i, i == n - 1);
      return;
    end
    // stable insertion sort by y then x
    for (int i = 0; i < n; i++) begin
      v = i;
      j = i;
      while (j > 0 && ranks_lower(v, ord[j-1])) begin
        ord[j] = ord[j-1];
        j--;
      end
      ord[j] = v;
    end
    top = 0;
    stk[top++] = ord[0];
    stk[top++] = ord[1];
    for (int i = 2; i < n; i++) begin
      while (top > 1 && top >= 2 && turn_val(stk[top-2], stk[top-1], ord[i]) <= 0) top--;
      if (top < MAX_POINTS + 1) stk[top++] = ord[i];
    end
    mid = top;
    if (top < MAX_POINTS + 1) stk[top++] = ord[n-2];
    for (int i = n - 2; i > 0; i--) begin
      p = ord[i-1];
      while (top > mid && top >= 2 && turn_val(stk[top-2], stk[top-1], p) <= 0) top--;
      if (top < MAX_POINTS + 1) stk[top++] = p;
    end
    for (int i = 0; i < top; i++) add_vertex(stk[i], i == top - 1);
  endfunction

  task automatic report(input string what);
    $display("[%0t] hull check: %s", $realtime, what);
    err_count++;
  endtask

  initial err_count = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      set_count <= 0;
      set_ovf <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        if (set_count < MAX_POINTS) begin
          set_x[set_count] = in_ch.point_x;
          set_y[set_count] = in_ch.point_y;
          set_count = set_count + 1;
        end else begin
          set_ovf = 1'b1;
        end
        if (in_ch.last_point) begin
          predict_hull();
          set_count = 0;
          set_ovf = 1'b0;
        end
      end
      if (out_ch.valid && out_ch.ready) begin
        vertex_t e;
        if (hull_q.size() == 0) begin
          report($sformatf("unexpected vertex (%0d,%0d)", out_ch.hull_x, out_ch.hull_y));
        end else begin
          e = hull_q.pop_front();
          if (out_ch.hull_x !== e.x)
            report($sformatf("hull_x %0d, want %0d", out_ch.hull_x, e.x));
          if (out_ch.hull_y !== e.y)
            report($sformatf("hull_y %0d, want %0d", out_ch.hull_y, e.y));
          if (out_ch.last_vertex !== e.last)
            report($sformatf("last_vertex %b, want %b", out_ch.last_vertex, e.last));
          if (out_ch.overflowed !== e.ovf)
            report($sformatf("overflowed %b, want %b", out_ch.overflowed, e.ovf));
        end
      end
    end
  end

endmodule

// ----- verif/tb.sv -----
module tb;
  import chmc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CAP = 32;
  // longest stretch with no word moving on either side: a full set sorted and
  // chained, a long receiver hold-off, plus plenty of margin
  localparam int unsigned QUIET_LIMIT = 20000;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned TARGET_WORDS = 120;

  // coordinate flavors for random sets
  typedef enum int {
    CO_FULL,
    CO_CLUSTER,
    CO_GRID,
    CO_EDGE
  } coord_mode_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  chmc_in_if  in_ch ();
  chmc_out_if out_ch ();

  int errs;
  int due;
  int words_sent;
  int burst_left;
  bit hold_req;

  convex_hull_monotone_chain #(.MAX_POINTS(CAP)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  chmc_hull_checker #(.MAX_POINTS(CAP)) u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ch        (in_ch),
    .out_ch       (out_ch),
    .err_count    (errs),
    .vertices_due (due)
  );

  always #10 clk = ~clk;

  // watchdog: cycles in which no word moves on either channel
  int quiet;
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
        $display("convex_hull_monotone_chain: mismatch");
        $finish;
      end
    end
  end

  // receiver: cycles through its own stall patterns, with a long hold-off on request
  initial begin
    int mode, span;
    out_ch.ready <= 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_req) begin
        // long hold-off so the block fills and pushes back on input
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      mode = $urandom_range(0, 3);
      span = $urandom_range(5, 60);
      repeat (span) begin
        case (mode)
          0: out_ch.ready <= 1'b1;                        // no stalls at all
          1: out_ch.ready <= ($urandom_range(0, 1) == 1);  // coin flip
          2: out_ch.ready <= ($urandom_range(0, 3) != 0);  // rare stalls
          default: out_ch.ready <= ($urandom_range(0, 3) == 0); // mostly stalled
        endcase
        @(posedge clk);
      end
    end
  end

  // one word on the input channel; valid stays up within a burst
  task automatic send_point(input logic signed [COORD_W-1:0] x,
                            input logic signed [COORD_W-1:0] y, input bit last);
    in_ch.valid      <= 1'b1;
    in_ch.point_x    <= x;
    in_ch.point_y    <= y;
    in_ch.last_point <= last;
    do @(posedge clk); while (!in_ch.ready);
    words_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      // burst over: drop valid and idle a random gap
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = $urandom_range(0, 12);
    end
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (due != 0) @(posedge clk);
  endtask

  function automatic logic signed [COORD_W-1:0] pick_coord(coord_mode_t m);
    logic [COORD_W-1:0] r;
    case (m)
      CO_FULL:    r = COORD_W'($urandom());
      CO_CLUSTER: r = COORD_W'($signed($urandom_range(0, 6)) - 3);
      CO_GRID:    r = COORD_W'(($signed($urandom_range(0, 4)) - 2) * 16);
      default: begin
        // near the limits of the range
        r = $urandom_range(0, 1) ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
        r[1:0] = 2'($urandom());
      end
    endcase
    return r;
  endfunction

  task automatic send_set(input int n, input coord_mode_t m);
    for (int i = 0; i < n; i++)
      send_point(pick_coord(m), pick_coord(m), i == n - 1);
  endtask

  localparam logic signed [COORD_W-1:0] CMAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic signed [COORD_W-1:0] CMIN = {1'b1, {(COORD_W-1){1'b0}}};

  initial begin
    coord_mode_t cm;
    int n;
    in_ch.valid      <= 1'b0;
    in_ch.point_x    <= '0;
    in_ch.point_y    <= '0;
    in_ch.last_point <= 1'b0;
    words_sent = 0;
    burst_left = 0;
    hold_req = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: sets of one, two and three points pass through unchanged
    send_point(CMAX, CMIN, 1'b1);
    send_point(CMIN, CMAX, 1'b0);
    send_point(20'sd0, 20'sd0, 1'b1);
    send_point(20'sd5, -20'sd5, 1'b0);
    send_point(20'sd5, -20'sd5, 1'b0);
    send_point(-20'sd1, 20'sd1, 1'b1);
    // square at the corners of the range, interior point dropped
    send_point(CMIN, CMIN, 1'b0);
    send_point(CMAX, CMAX, 1'b0);
    send_point(CMAX, CMIN, 1'b0);
    send_point(CMIN, CMAX, 1'b0);
    send_point(20'sd0, 20'sd0, 1'b1);
    // collinear points on a diagonal: only the two ends survive
    for (int i = 0; i < 5; i++)
      send_point(20'(i * 3), 20'(i * 3), i == 4);
    // four identical points
    for (int i = 0; i < 4; i++)
      send_point(-20'sd7, 20'sd9, i == 3);

    // sender pauses until every vertex has come back
    drain();

    // long receiver hold-off while the next two sets keep coming
    hold_req = 1'b1;
    // store overflow: more points than the store holds, last one dropped too
    send_set(CAP + 3, CO_FULL);
    // exactly full, no overflow
    send_set(CAP, CO_CLUSTER);

    // random sets up to the word budget
    for (int s = 0; words_sent < TARGET_WORDS; s++) begin
      if (s == 6) drain();
      cm = coord_mode_t'($urandom_range(0, 3));
      case ($urandom_range(0, 9))
        0:       n = $urandom_range(1, 3);      // pass-through sets
        1:       n = $urandom_range(CAP - 2, CAP + 4);
        default: n = $urandom_range(4, 12);
      endcase
      send_set(n, cm);
    end

    drain();
    repeat (50) @(posedge clk);
    if (errs == 0 && due == 0) begin
      $display("convex_hull_monotone_chain: match");
    end else begin
      $display("convex_hull_monotone_chain: mismatch");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/chmc_pkg.sv
rtl/core/chmc_if.sv
rtl/core/chmc_datapath.sv
rtl/core/chmc_ctrl.sv
rtl/core/convex_hull_monotone_chain.sv
verif/chmc_hull_checker.sv
verif/tb.sv
